FILE: rtl/core/rmq_pkg.sv
// ----------------------------------------------------------------------------
// Rotation matrix to quaternion: shared package
// Word types of both channels, field widths and component codes.
// ----------------------------------------------------------------------------
package rmq_pkg;

  localparam int unsigned RmqFracBits = 14;
  localparam int unsigned FieldW      = 16;
  // Magnitude of a sum or difference of two matrix elements.
  localparam int unsigned MagW        = 17;
  // Quotient bits kept before saturation.
  localparam int unsigned QuoW        = 17;

  // Quaternion component codes.
  localparam logic [1:0] CompX = 2'd0;
  localparam logic [1:0] CompY = 2'd1;
  localparam logic [1:0] CompZ = 2'd2;
  localparam logic [1:0] CompW = 2'd3;

  typedef struct packed {
    logic signed [FieldW-1:0] m00;
    logic signed [FieldW-1:0] m01;
    logic signed [FieldW-1:0] m02;
    logic signed [FieldW-1:0] m10;
    logic signed [FieldW-1:0] m11;
    logic signed [FieldW-1:0] m12;
    logic signed [FieldW-1:0] m20;
    logic signed [FieldW-1:0] m21;
    logic signed [FieldW-1:0] m22;
  } rmq_in_t;

  typedef struct packed {
    logic signed [FieldW-1:0] quat_x;
    logic signed [FieldW-1:0] quat_y;
    logic signed [FieldW-1:0] quat_z;
    logic signed [FieldW-1:0] quat_w;
    logic                     degenerate;
  } rmq_out_t;

  // Per-word control that rides along the pipeline.
  typedef struct packed {
    logic       degen;
    logic [1:0] hsel;
    logic [2:0] neg;
  } rmq_side_t;

endpackage

FILE: rtl/core/rmq_sqrt.sv
// ----------------------------------------------------------------------------
// Pipelined integer square root
// Restoring method, one result bit per register stage.
// ----------------------------------------------------------------------------
module rmq_sqrt #(
  parameter int unsigned IN_W = 32
) (
  input  logic                      clk_i,
  input  logic [(IN_W+1)/2-1:0]     en_i,
  input  logic [IN_W-1:0]           rad_i,
  output logic [(IN_W+1)/2-1:0]     root_o
);

  localparam int unsigned SW  = (IN_W + 1) / 2;
  localparam int unsigned RMW = SW + 2;
  localparam int unsigned PW  = 2 * SW;

  logic [RMW-1:0] rem_q  [SW];
  logic [SW-1:0]  root_q [SW];
  logic [PW-1:0]  x_q    [SW];

  for (genvar t = 0; t < SW; t++) begin : g_stage
    logic [RMW-1:0] p_rem;
    logic [SW-1:0]  p_root;
    logic [PW-1:0]  p_x;
    logic [RMW-1:0] cur;
    logic [RMW-1:0] trial;
    logic [RMW-1:0] diff;
    logic           ge;

    if (t == 0) begin : g_first
      assign p_rem  = '0;
      assign p_root = '0;
      assign p_x    = PW'(rad_i);
    end else begin : g_next
      assign p_rem  = rem_q[t-1];
      assign p_root = root_q[t-1];
      assign p_x    = x_q[t-1];
    end

    assign cur   = {p_rem[SW-1:0], p_x[PW-1 -: 2]};
    assign trial = {p_root, 2'b01};
    assign ge    = cur >= trial;
    assign diff  = cur - trial;

    always_ff @(posedge clk_i) begin
      if (en_i[t]) begin
        rem_q[t]  <= ge ? diff : cur;
        root_q[t] <= {p_root[SW-2:0], ge};
        x_q[t]    <= p_x << 2;
      end
    end
  end

  assign root_o = root_q[SW-1];

endmodule

FILE: rtl/core/rmq_div.sv
// ----------------------------------------------------------------------------
// Pipelined rounding divider
// Computes (mag * 2^F + root) / (2 * root), one quotient bit per stage.
// ----------------------------------------------------------------------------
module rmq_div
  import rmq_pkg::*;
#(
  parameter int unsigned FRAC_BITS = RmqFracBits,
  parameter int unsigned ROOT_W    = 16
) (
  input  logic              clk_i,
  input  logic [QuoW:0]     en_i,
  input  logic [ROOT_W-1:0] root_i,
  input  logic [MagW-1:0]   mag_i,
  output logic [QuoW-1:0]   quo_o,
  output logic              ovf_o
);

  localparam int unsigned NW = ((MagW + FRAC_BITS > ROOT_W) ? MagW + FRAC_BITS : ROOT_W) + 1;
  localparam int unsigned DW = ROOT_W + 1;

  logic [NW-1:0] num;
  logic [NW-1:0] hi;
  logic [DW-1:0] den;
  logic          ovf;

  // The quotient fits QuoW bits only when the upper part of the numerator
  // is below the divisor; otherwise the result saturates anyway.
  assign num = (NW'(mag_i) << FRAC_BITS) + NW'(root_i);
  assign den = {root_i, 1'b0};
  assign hi  = num >> QuoW;
  assign ovf = hi >= NW'(den);

  logic [DW-1:0]   rem_q [QuoW+1];
  logic [QuoW-1:0] nlo_q [QuoW+1];
  logic [QuoW-1:0] quo_q [QuoW+1];
  logic [DW-1:0]   den_q [QuoW+1];
  logic            ovf_q [QuoW+1];

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      rem_q[0] <= hi[DW-1:0];
      nlo_q[0] <= num[QuoW-1:0];
      quo_q[0] <= '0;
      den_q[0] <= den;
      ovf_q[0] <= ovf;
    end
  end

  for (genvar t = 1; t <= QuoW; t++) begin : g_stage
    logic [DW:0] cur;
    logic [DW:0] diff;
    logic        ge;

    assign cur  = {rem_q[t-1], nlo_q[t-1][QuoW-1]};
    assign ge   = cur >= {1'b0, den_q[t-1]};
    assign diff = cur - {1'b0, den_q[t-1]};

    always_ff @(posedge clk_i) begin
      if (en_i[t]) begin
        rem_q[t] <= ge ? diff[DW-1:0] : cur[DW-1:0];
        nlo_q[t] <= nlo_q[t-1] << 1;
        quo_q[t] <= {quo_q[t-1][QuoW-2:0], ge};
        den_q[t] <= den_q[t-1];
        ovf_q[t] <= ovf_q[t-1];
      end
    end
  end

  assign quo_o = quo_q[QuoW];
  assign ovf_o = ovf_q[QuoW];

endmodule

FILE: rtl/core/rotation_matrix_to_quaternion.sv
// ----------------------------------------------------------------------------
// Rotation matrix to quaternion
// Shepperd's method in fixed point, fully pipelined.
// ----------------------------------------------------------------------------
// The input channel carries one word per matrix: nine signed elements with
// FRAC_BITS fraction bits. The output channel carries one word per matrix:
// the four quaternion components, saturated to 16 bits, and a degenerate flag
// that is set when the radicand was not positive and the identity was sent.
// Both channels use a valid/ready handshake.
// SW = (max(FRAC_BITS,17) + 1 + FRAC_BITS + 1) / 2 is the number of square root
// stages. The pipeline takes a new word every cycle while a stalled receiver
// does not hold it up; its length is set by the square root (one bit per stage)
// and the divider (one quotient bit per stage).
// Each stage carries its own valid bit and loads whenever it is empty or the
// stage after it moves, so bubbles close up while the receiver stalls and
// nothing is dropped or repeated. A stalled output holds its word.
// Reset clears all valid bits; the datapath registers are not reset.
// ----------------------------------------------------------------------------
module rotation_matrix_to_quaternion
  import rmq_pkg::*;
#(
  parameter int unsigned FRAC_BITS = RmqFracBits
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  rmq_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output rmq_out_t out_data_o
);

  // Radicand width (signed), then the square root input and output widths.
  localparam int unsigned RW   = ((FRAC_BITS > 17) ? FRAC_BITS : 17) + 2;
  localparam int unsigned RADW = RW - 1;
  localparam int unsigned XW   = RADW + FRAC_BITS;
  localparam int unsigned SW   = (XW + 1) / 2;
  // Stage map: 0 front end, 1..SW square root, DP divider setup,
  // DP+1..DQ quotient bits, OS output register.
  localparam int unsigned DP   = SW + 1;
  localparam int unsigned DQ   = SW + 1 + QuoW;
  localparam int unsigned OS   = DQ + 1;
  localparam int unsigned L    = OS + 1;

  localparam logic [RW-1:0]     One    = RW'(1) << FRAC_BITS;
  localparam logic [FieldW-1:0] OneSat = (FRAC_BITS >= 15) ? 16'h7fff
                                                            : FieldW'(1 << FRAC_BITS);

  // --------------------------------------------------------------------------
  // Pipeline control: a stage loads when it is empty or its successor loads.
  // --------------------------------------------------------------------------
  logic [L-1:0] v_q;
  logic [L-1:0] adv;

  always_comb begin
    adv[L-1] = !v_q[L-1] || out_ready_i;
    for (int k = L - 2; k >= 0; k--) begin
      adv[k] = !v_q[k] || adv[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (adv[0]) begin
        v_q[0] <= in_valid_i;
      end
      for (int k = 1; k < L; k++) begin
        if (adv[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  assign in_ready_o  = adv[0];
  assign out_valid_o = v_q[L-1];

  // --------------------------------------------------------------------------
  // Front end: trace, branch choice, radicand and the three divided terms.
  // --------------------------------------------------------------------------
  logic signed [RW-1:0]   e00, e11, e22, trace, rad;
  logic signed [MagW-1:0] s01, s02, s12, t10, t02, t21;
  logic signed [MagW-1:0] lane [3];
  logic                   pos, degen;
  logic [1:0]             isel, hsel;
  rmq_side_t              side_d;
  logic [MagW-1:0]        mag_d [3];
  logic [RADW-1:0]        rad_d;

  assign e00   = RW'(in_data_i.m00);
  assign e11   = RW'(in_data_i.m11);
  assign e22   = RW'(in_data_i.m22);
  assign trace = e00 + e11 + e22;
  assign pos   = !trace[RW-1] && (trace != '0);

  // Symmetric sums and antisymmetric differences of the off-diagonal pairs.
  assign s01 = MagW'(in_data_i.m01) + MagW'(in_data_i.m10);
  assign s02 = MagW'(in_data_i.m02) + MagW'(in_data_i.m20);
  assign s12 = MagW'(in_data_i.m12) + MagW'(in_data_i.m21);
  assign t21 = MagW'(in_data_i.m21) - MagW'(in_data_i.m12);
  assign t02 = MagW'(in_data_i.m02) - MagW'(in_data_i.m20);
  assign t10 = MagW'(in_data_i.m10) - MagW'(in_data_i.m01);

  always_comb begin
    // Largest diagonal element; a later one wins only when strictly greater.
    isel = CompX;
    if (in_data_i.m11 > in_data_i.m00) begin
      isel = CompY;
    end
    if ((isel == CompY && in_data_i.m22 > in_data_i.m11) ||
        (isel == CompX && in_data_i.m22 > in_data_i.m00)) begin
      isel = CompZ;
    end

    // The lanes hold the three components other than the root one, in order.
    if (pos) begin
      hsel    = CompW;
      rad     = trace + One;
      lane[0] = t21;
      lane[1] = t02;
      lane[2] = t10;
    end else begin
      hsel = isel;
      unique case (isel)
        CompY: begin
          rad     = e11 - e22 - e00 + One;
          lane[0] = s01;
          lane[1] = s12;
          lane[2] = t02;
        end
        CompZ: begin
          rad     = e22 - e00 - e11 + One;
          lane[0] = s02;
          lane[1] = s12;
          lane[2] = t10;
        end
        default: begin
          rad     = e00 - e11 - e22 + One;
          lane[0] = s01;
          lane[1] = s02;
          lane[2] = t21;
        end
      endcase
    end

    degen = !pos && (rad[RW-1] || rad == '0);
    // A degenerate word still runs through with a radicand of one, so the
    // divider never sees a zero divisor.
    rad_d = degen ? RADW'(1) : rad[RADW-1:0];

    for (int n = 0; n < 3; n++) begin
      side_d.neg[n] = lane[n][MagW-1];
      mag_d[n]      = lane[n][MagW-1] ? MagW'(-lane[n]) : MagW'(lane[n]);
    end
    side_d.degen = degen;
    side_d.hsel  = hsel;
  end

  rmq_side_t       side_q [L-1];
  logic [MagW-1:0] mag_q  [SW+1][3];
  logic [RADW-1:0] rad_q;

  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      side_q[0] <= side_d;
      mag_q[0]  <= mag_d;
      rad_q     <= rad_d;
    end
    for (int k = 1; k < L - 1; k++) begin
      if (adv[k]) begin
        side_q[k] <= side_q[k-1];
      end
    end
    for (int k = 1; k <= SW; k++) begin
      if (adv[k]) begin
        mag_q[k] <= mag_q[k-1];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Square root of rad * 2^F. Half of it is the root component.
  // --------------------------------------------------------------------------
  logic [SW-1:0] root;

  rmq_sqrt #(
    .IN_W (XW)
  ) u_sqrt (
    .clk_i  (clk_i),
    .en_i   (adv[SW:1]),
    .rad_i  ({rad_q, {FRAC_BITS{1'b0}}}),
    .root_o (root)
  );

  logic [SW-2:0] half_q [QuoW+1];

  always_ff @(posedge clk_i) begin
    if (adv[DP]) begin
      half_q[0] <= root[SW-1:1];
    end
    for (int k = 1; k <= QuoW; k++) begin
      if (adv[DP+k]) begin
        half_q[k] <= half_q[k-1];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Three divider lanes share the root as divisor.
  // --------------------------------------------------------------------------
  logic [QuoW-1:0] quo [3];
  logic            ovf [3];

  for (genvar n = 0; n < 3; n++) begin : g_lane
    rmq_div #(
      .FRAC_BITS (FRAC_BITS),
      .ROOT_W    (SW)
    ) u_div (
      .clk_i  (clk_i),
      .en_i   (adv[DQ:DP]),
      .root_i (root),
      .mag_i  (mag_q[SW][n]),
      .quo_o  (quo[n]),
      .ovf_o  (ovf[n])
    );
  end

  // --------------------------------------------------------------------------
  // Output stage: route components, restore signs and saturate.
  // --------------------------------------------------------------------------
  function automatic logic [FieldW-1:0] lane_val(logic [QuoW-1:0] q, logic o, logic n);
    logic [FieldW-1:0] res;
    if (!n) begin
      res = (o || q > QuoW'(32767)) ? 16'h7fff : q[FieldW-1:0];
    end else begin
      res = (o || q > QuoW'(32768)) ? 16'h8000 : FieldW'(16'd0 - q[FieldW-1:0]);
    end
    return res;
  endfunction

  rmq_side_t         side_o;
  logic [SW+15:0]    half_x;
  logic [FieldW-1:0] half_sat;
  logic [FieldW-1:0] comp [4];
  logic [1:0]        ln;
  rmq_out_t          out_d;
  rmq_out_t          out_q;

  assign side_o   = side_q[L-2];
  assign half_x   = (SW + 16)'(half_q[QuoW]);
  assign half_sat = (half_x > (SW + 16)'(32767)) ? 16'h7fff : half_x[FieldW-1:0];

  always_comb begin
    ln = '0;
    for (int c = 0; c < 4; c++) begin
      ln = 2'(c) - ((2'(c) > side_o.hsel) ? 2'd1 : 2'd0);
      if (side_o.degen) begin
        comp[c] = (2'(c) == CompW) ? OneSat : '0;
      end else if (2'(c) == side_o.hsel) begin
        comp[c] = half_sat;
      end else begin
        comp[c] = lane_val(quo[ln], ovf[ln], side_o.neg[ln]);
      end
    end
    out_d.quat_x     = comp[CompX];
    out_d.quat_y     = comp[CompY];
    out_d.quat_z     = comp[CompZ];
    out_d.quat_w     = comp[CompW];
    out_d.degenerate = side_o.degen;
  end

  always_ff @(posedge clk_i) begin
    if (adv[OS]) begin
      out_q <= out_d;
    end
  end

  assign out_data_o = out_q;

endmodule
